/* rtl/core/mrld_pkg.sv */
// ============================================================================
// mrld_pkg
// Shared widths, register indexes and the history unit control bundle for the
// mask run-length / LZSS decoder.
// ============================================================================
package mrld_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int OFFSET_W   = 10;
    localparam int LEN_W      = 6;
    localparam int COUNT_W    = 17;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 1'b0,
        CFG_OUTPUT_LENGTH = 1'b1
    } t_cfg_idx;

    // Control from the sequencer to the history unit
    typedef struct packed {
        logic                restart;
        logic                wr_en;
        logic [BYTE_W-1:0]   wr_data;
        logic                rd_load;
        logic [OFFSET_W-1:0] rd_offset;
        logic                rd_en;
    } t_hist_ctrl;

endpackage

/* rtl/core/mrld_in_if.sv */
// ============================================================================
// mrld_in_if
// Compressed byte channel: valid/ready handshake with one byte of payload.
// ============================================================================
interface mrld_in_if;
    logic                        valid;
    logic                        ready;
    logic [mrld_pkg::BYTE_W-1:0] compressed_byte;

    modport source (output valid, output compressed_byte, input ready);
    modport sink   (input valid, input compressed_byte, output ready);
endinterface

/* rtl/core/mrld_out_if.sv */
// ============================================================================
// mrld_out_if
// Decompressed byte channel: valid/ready handshake, one byte and a last flag.
// ============================================================================
interface mrld_out_if;
    logic                        valid;
    logic                        ready;
    logic [mrld_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* rtl/core/mask_rle_and_lzss_decoder.sv */
// ============================================================================
// mask_rle_and_lzss_decoder
// Byte-stream decompressor: mask run-length groups (mode 0) or LZSS tokens
// with a ring history (mode 1), one compressed byte in per transaction.
// ============================================================================
//
//  Channel   Dir  Payload                        Transaction
//  i_in      in   compressed_byte[7:0]           valid & ready
//  o_out     out  out_byte[7:0], last            valid & ready
//  i_cfg_*   in   index[0], data[15:0]           i_cfg_we high
//
//  Control, token high and LZSS literal bytes are decoded as they are taken.
//  In mode 0 a fill byte, or a literal that leaves its group open, starts a
//  fill run of one fill byte per clear bit up to a set bit, the group end or
//  the stream end. A match loads its offset, then reads the ring and emits
//  one byte a cycle unless stalled (up to 63). A fill count makes unwritten
//  ring entries read as zero; a stalled output holds the sequencer and the
//  pending read.
module mask_rle_and_lzss_decoder #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mrld_in_if.sink                         i_in,
    mrld_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [mrld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrld_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = mrld_pkg::COUNT_W;
    localparam int LW = mrld_pkg::LEN_W;
    localparam int BW = mrld_pkg::BYTE_W;
    localparam logic [2:0] BIT_TOP = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_COPY
    } t_state;

    // Position within a group: control byte, first byte, second byte
    typedef enum logic [1:0] {
        PH_CTRL,
        PH_DATA,
        PH_SECOND
    } t_phase;

    t_state                         r_state,  n_state;
    t_phase                         r_phase,  n_phase;
    logic [BW-1:0]                  r_ctrl,   n_ctrl;
    logic [2:0]                     r_bitpos, n_bitpos;
    logic [BW-1:0]                  r_fill,   n_fill;
    logic [BW-1:0]                  r_thb,    n_thb;
    logic [CW-1:0]                  r_produced, n_produced;
    logic [LW-1:0]                  r_em_left, n_em_left;
    logic [LW-1:0]                  r_rd_left, n_rd_left;
    logic                           r_pend,   n_pend;
    logic                           r_mode;
    logic [mrld_pkg::CFG_DATA_W-1:0] r_out_len;
    logic                           r_out_valid, n_out_valid;
    logic [BW-1:0]                  r_out_byte,  n_out_byte;
    logic                           r_out_last,  n_out_last;

    logic [CW-1:0]                  w_target;
    logic [CW-1:0]                  w_remain;
    logic [CW-1:0]                  w_prod_inc;
    logic                           w_done;
    logic                           w_cur_bit;
    logic                           w_group_end;
    logic [2:0]                     w_nb_bitpos;
    logic                           w_emit_ok;
    logic                           w_in_ready;
    logic                           w_accept;
    logic                           w_emit;
    logic [BW-1:0]                  w_emit_byte;
    logic [LW-1:0]                  w_len;
    logic [LW-1:0]                  w_count;
    logic                           w_consume;
    logic                           w_issue;
    logic [BW-1:0]                  w_hist_q;
    mrld_pkg::t_hist_ctrl           w_hctl;

    // Stream target, end test and control bit bookkeeping
    assign w_target    = r_mode ? CW'(r_out_len) : CW'({r_out_len[15:3], 3'b000});
    assign w_done      = r_produced >= w_target;
    assign w_remain    = w_target - r_produced;
    assign w_prod_inc  = r_produced + CW'(1);
    assign w_cur_bit   = r_ctrl[r_bitpos];
    assign w_group_end = (r_bitpos == 3'd0);
    assign w_nb_bitpos = w_group_end ? BIT_TOP : r_bitpos - 3'd1;

    // Match length, cut off at the stream target
    assign w_len   = r_thb[7:2];
    assign w_count = (w_remain < CW'(w_len)) ? w_remain[LW-1:0] : w_len;

    assign w_emit_ok  = !r_out_valid || o_out.ready;
    assign w_in_ready = (r_state == S_IDLE) && w_emit_ok;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_consume  = (r_state == S_COPY) && r_pend && w_emit_ok;
    assign w_issue    = (r_state == S_COPY) && (r_rd_left != '0) && (!r_pend || w_consume);

    mrld_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_hctl),
        .o_rd_data (w_hist_q)
    );

    // Sequencer: decode input bytes, run fills and copies
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_ctrl      = r_ctrl;
        n_bitpos    = r_bitpos;
        n_fill      = r_fill;
        n_thb       = r_thb;
        n_em_left   = r_em_left;
        n_rd_left   = r_rd_left;
        n_pend      = r_pend;
        w_emit      = 1'b0;
        w_emit_byte = i_in.compressed_byte;
        w_hctl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !w_done) begin
                    if (r_phase != PH_DATA && r_phase != PH_SECOND) begin
                        n_ctrl   = i_in.compressed_byte;
                        n_bitpos = BIT_TOP;
                        n_phase  = PH_DATA;
                    end else if (!r_mode) begin
                        if (r_phase == PH_DATA) begin
                            n_fill  = i_in.compressed_byte;
                            n_state = S_FILL;
                        end else begin
                            w_emit   = 1'b1;
                            n_bitpos = w_nb_bitpos;
                            if (w_group_end) begin
                                n_phase = PH_CTRL;
                            end else begin
                                n_state = S_FILL;
                            end
                        end
                    end else if (r_phase == PH_DATA) begin
                        if (w_cur_bit) begin
                            n_thb   = i_in.compressed_byte;
                            n_phase = PH_SECOND;
                        end else begin
                            w_emit   = 1'b1;
                            n_bitpos = w_nb_bitpos;
                            n_phase  = w_group_end ? PH_CTRL : PH_DATA;
                        end
                    end else begin
                        if (w_count == '0) begin
                            n_bitpos = w_nb_bitpos;
                            n_phase  = w_group_end ? PH_CTRL : PH_DATA;
                        end else begin
                            w_hctl.rd_load   = 1'b1;
                            w_hctl.rd_offset = {r_thb[1:0], i_in.compressed_byte};
                            n_rd_left        = w_count;
                            n_em_left        = w_count;
                            n_pend           = 1'b0;
                            n_state          = S_COPY;
                        end
                    end
                end
            end
            S_FILL: begin
                w_emit_byte = r_fill;
                if (w_done) begin
                    n_phase = PH_CTRL;
                    n_state = S_IDLE;
                end else if (w_cur_bit) begin
                    n_phase = PH_SECOND;
                    n_state = S_IDLE;
                end else if (w_emit_ok) begin
                    w_emit   = 1'b1;
                    n_bitpos = w_nb_bitpos;
                    if (w_group_end) begin
                        n_phase = PH_CTRL;
                        n_state = S_IDLE;
                    end
                end
            end
            S_COPY: begin
                w_emit_byte = w_hist_q;
                if (w_consume) begin
                    w_emit    = 1'b1;
                    n_em_left = r_em_left - LW'(1);
                    if (r_em_left == LW'(1)) begin
                        n_bitpos = w_nb_bitpos;
                        n_phase  = w_group_end ? PH_CTRL : PH_DATA;
                        n_state  = S_IDLE;
                    end
                end
                if (w_issue) begin
                    w_hctl.rd_en = 1'b1;
                    n_rd_left    = r_rd_left - LW'(1);
                end
                n_pend = w_issue || (r_pend && !w_consume);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Emit: load the output register and, in mode 1, record the byte in the ring
        w_hctl.restart = i_cfg_we;
        w_hctl.wr_en   = w_emit && r_mode;
        w_hctl.wr_data = w_emit_byte;
        n_produced     = r_produced;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_byte     = r_out_byte;
        n_out_last     = r_out_last;
        if (w_emit) begin
            n_produced  = w_prod_inc;
            n_out_valid = 1'b1;
            n_out_byte  = w_emit_byte;
            n_out_last  = (w_prod_inc == w_target);
        end
    end

    // State, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_CTRL;
            r_ctrl      <= '0;
            r_bitpos    <= BIT_TOP;
            r_fill      <= '0;
            r_thb       <= '0;
            r_produced  <= '0;
            r_em_left   <= '0;
            r_rd_left   <= '0;
            r_pend      <= 1'b0;
            r_mode      <= 1'b0;
            r_out_len   <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (mrld_pkg::t_cfg_idx'(i_cfg_index))
                mrld_pkg::CFG_MODE:          r_mode    <= i_cfg_data[0];
                mrld_pkg::CFG_OUTPUT_LENGTH: r_out_len <= i_cfg_data;
            endcase
            r_state     <= S_IDLE;
            r_phase     <= PH_CTRL;
            r_ctrl      <= '0;
            r_bitpos    <= BIT_TOP;
            r_fill      <= '0;
            r_thb       <= '0;
            r_produced  <= '0;
            r_em_left   <= '0;
            r_rd_left   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_ctrl      <= n_ctrl;
            r_bitpos    <= n_bitpos;
            r_fill      <= n_fill;
            r_thb       <= n_thb;
            r_produced  <= n_produced;
            r_em_left   <= n_em_left;
            r_rd_left   <= n_rd_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_out_byte  <= n_out_byte;
            r_out_last  <= n_out_last;
        end
    end

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    // Reads issued but not yet emitted number exactly the pending flag, at most one
    a_copy_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_em_left == r_rd_left + LW'(r_pend)))
        else $error("copy read and emit counts out of step");

    // Never emit past the stream target
    a_no_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> !w_done)
        else $error("byte emitted after stream end");

    // Never overwrite an output byte that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || o_out.ready))
        else $error("output register overwritten");

    // The byte flagged last ends the stream
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && n_out_last && !i_cfg_we) |=> w_done)
        else $error("last flag without stream end");

endmodule

/* rtl/core/mrld_ram.sv */
// ============================================================================
// mrld_ram
// Generic single-clock RAM, one write port and one read port, read-first,
// read data registered and held while the read enable is low.
// ============================================================================
module mrld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; a read at the written address sees old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/mrld_hist.sv */
// ============================================================================
// mrld_hist
// History ring for LZSS copies: ring RAM, write pointer, fill count standing
// in for the clear, copy read pointer and same-edge write forwarding.
// ============================================================================
module mrld_hist #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mrld_pkg::t_hist_ctrl        i_ctrl,
    output logic [mrld_pkg::BYTE_W-1:0] o_rd_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FULL      = FW'(HISTORY_DEPTH);

    logic [AW-1:0]               r_wp;
    logic [FW-1:0]               r_fill;
    logic [AW-1:0]               r_rd_ptr;
    logic                        r_fwd_hit;
    logic [mrld_pkg::BYTE_W-1:0] r_fwd_data;
    logic                        r_rd_valid;

    logic [AW-1:0]               w_wp_next;
    logic [AW-1:0]               w_rd_next;
    logic [AW:0]                 w_back;
    logic [AW-1:0]               w_start;
    logic [mrld_pkg::BYTE_W-1:0] w_ram_q;

    // Pointer arithmetic modulo the ring depth
    assign w_wp_next = (r_wp == LAST_ADDR) ? '0 : r_wp + AW'(1);
    assign w_rd_next = (r_rd_ptr == LAST_ADDR) ? '0 : r_rd_ptr + AW'(1);
    assign w_back    = {1'b0, r_wp} - (AW + 1)'(i_ctrl.rd_offset);
    assign w_start   = w_back[AW] ? AW'(w_back + DEPTH_X) : w_back[AW-1:0];

    mrld_ram #(
        .WIDTH (mrld_pkg::BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr_en),
        .i_waddr (r_wp),
        .i_wdata (i_ctrl.wr_data),
        .i_re    (i_ctrl.rd_en),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_ram_q)
    );

    // Advance write pointer and fill count; restart empties the ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_ctrl.restart) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_ctrl.wr_en) begin
            r_wp <= w_wp_next;
            if (r_fill != FULL) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    // Copy read pointer, forwarding and validity travel with the read data
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_load) begin
            r_rd_ptr <= w_start;
        end else if (i_ctrl.rd_en) begin
            r_rd_ptr <= w_rd_next;
        end
        if (i_ctrl.rd_en) begin
            r_fwd_hit  <= i_ctrl.wr_en && (r_wp == r_rd_ptr);
            r_fwd_data <= i_ctrl.wr_data;
            r_rd_valid <= FW'(r_rd_ptr) < r_fill;
        end
    end

    // Entries never written since restart read as zero
    assign o_rd_data = r_fwd_hit  ? r_fwd_data :
                       r_rd_valid ? w_ram_q    : '0;

endmodule

/* dv/mrld_decode_checker.sv */
// ============================================================================
// mrld_decode_checker
// Watches the compressed and decompressed channels and the register port of
// the decoder, keeps its own copy of the decoding state and history ring, and
// compares every decompressed transaction with the oldest predicted byte.
// ============================================================================
module mrld_decode_checker
    import mrld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mrld_in_if                    i_in_mon,
    mrld_out_if                   i_out_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int RING_DEPTH = 1024;

    typedef enum logic [1:0] {
        DEC_CONTROL,
        DEC_FILL_OR_TOKEN,
        DEC_DATA
    } t_dec_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_decoded_byte;

    t_decoded_byte      decoded_q[$];

    logic               cur_mode;
    logic [15:0]        cur_length;
    t_dec_phase         dec_phase;
    logic [BYTE_W-1:0]  ctrl_bits;
    logic [2:0]         bit_pos;
    logic [BYTE_W-1:0]  fill_byte;
    logic [BYTE_W-1:0]  token_hi;
    logic [BYTE_W-1:0]  history [RING_DEPTH];
    logic [OFFSET_W-1:0] wr_pos;
    logic [COUNT_W-1:0] produced;
    int                 fails = 0;

    // Mode 0 decodes whole groups only, so round the length down to a multiple of eight
    function automatic logic [COUNT_W-1:0] stream_target();
        return cur_mode ? {1'b0, cur_length} : {1'b0, cur_length & 16'hFFF8};
    endfunction

    function automatic bit stream_done();
        return produced >= stream_target();
    endfunction

    task automatic restart_decoder();
        dec_phase = DEC_CONTROL;
        ctrl_bits = '0;
        bit_pos   = 3'd7;
        fill_byte = '0;
        token_hi  = '0;
        for (int i = 0; i < RING_DEPTH; i++) history[i] = '0;
        wr_pos    = '0;
        produced  = '0;
    endtask

    task automatic emit_byte(input logic [BYTE_W-1:0] v);
        t_decoded_byte e;
        if (cur_mode) begin
            history[wr_pos] = v;
            wr_pos = wr_pos + 1'b1;
        end
        produced = produced + 1'b1;
        e.out_byte = v;
        e.last     = (produced == stream_target());
        decoded_q.push_back(e);
    endtask

    // Use up one control bit; report whether the group of eight has ended
    function automatic bit step_bit();
        if (bit_pos == 3'd0) begin
            bit_pos   = 3'd7;
            dec_phase = DEC_CONTROL;
            return 1'b1;
        end
        bit_pos = bit_pos - 1'b1;
        return 1'b0;
    endfunction

    // Mode 0: emit fill bytes until a literal is due, the group ends or the stream ends
    task automatic run_fill();
        bit stop;
        stop = 1'b0;
        while (!stop) begin
            if (stream_done()) begin
                dec_phase = DEC_CONTROL;
                stop = 1'b1;
            end else if (ctrl_bits[bit_pos]) begin
                dec_phase = DEC_DATA;
                stop = 1'b1;
            end else begin
                emit_byte(fill_byte);
                stop = step_bit();
            end
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0]    match_len;
        logic [OFFSET_W-1:0] match_off;
        if (stream_done()) return;
        if (dec_phase == DEC_CONTROL) begin
            ctrl_bits = b;
            bit_pos   = 3'd7;
            dec_phase = DEC_FILL_OR_TOKEN;
            return;
        end
        if (!cur_mode) begin
            if (dec_phase == DEC_FILL_OR_TOKEN) begin
                fill_byte = b;
                run_fill();
            end else begin
                emit_byte(b);
                if (!step_bit()) run_fill();
            end
        end else if (dec_phase == DEC_FILL_OR_TOKEN) begin
            if (ctrl_bits[bit_pos]) begin
                token_hi  = b;
                dec_phase = DEC_DATA;
            end else begin
                emit_byte(b);
                if (!step_bit()) dec_phase = DEC_FILL_OR_TOKEN;
            end
        end else begin
            // Copy one byte at a time so overlapping matches repeat themselves
            match_len = token_hi[7:2];
            match_off = {token_hi[1:0], b};
            for (int i = 0; i < match_len && !stream_done(); i++) begin
                emit_byte(history[wr_pos - match_off]);
            end
            if (!step_bit()) dec_phase = DEC_FILL_OR_TOKEN;
        end
    endtask

    task automatic check_output(input logic [BYTE_W-1:0] got_byte, input logic got_last);
        t_decoded_byte e;
        if (decoded_q.size() == 0) begin
            $error("out_byte: expected none, actual %02h (last %0b)", got_byte, got_last);
            fails++;
            return;
        end
        e = decoded_q.pop_front();
        if (got_byte !== e.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", e.out_byte, got_byte);
            fails++;
        end
        if (got_last !== e.last) begin
            $error("last: expected %0b, actual %0b", e.last, got_last);
            fails++;
        end
    endtask

    // Track register writes, predict on input transactions, compare on output ones
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode   = 1'b0;
            cur_length = '0;
            restart_decoder();
            decoded_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MODE)
                    cur_mode = i_cfg_data[0];
                else if (i_cfg_index == CFG_OUTPUT_LENGTH)
                    cur_length = i_cfg_data;
                restart_decoder();
            end
            if (i_in_mon.valid && i_in_mon.ready)
                decode_byte(i_in_mon.compressed_byte);
            if (i_out_mon.valid && i_out_mon.ready)
                check_output(i_out_mon.out_byte, i_out_mon.last);
        end
        o_fail_count <= fails;
        o_pending    <= decoded_q.size();
    end

endmodule

/* dv/tb_mask_rle_and_lzss_decoder.sv */
// ============================================================================
// tb_mask_rle_and_lzss_decoder
// Drives compressed streams into the decoder in both modes: a directed set of
// corner cases, then random run-length groups, LZSS token streams, a long
// LZSS stream that wraps the history ring, and plain noise. Both sides idle
// at random; the checker beside the block predicts and compares.
// ============================================================================
module tb_mask_rle_and_lzss_decoder;
    import mrld_pkg::*;

    localparam int ITEM_TARGET     = 230;
    localparam int MAX_GAP         = 9;
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    bit                    tx_burst;
    bit                    hold_off_req;
    int                    n_items;
    logic                  gen_mode;
    logic [15:0]           gen_length;

    mrld_in_if  in_ch();
    mrld_out_if out_ch();

    mask_rle_and_lzss_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    mrld_decode_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random hold-offs per transaction, bursts without idling, one long stall
    initial begin
        int  hold;
        int  burst_left;
        bit  held_long;
        hold       = 0;
        burst_left = 0;
        held_long  = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_ch.ready && out_ch.valid) begin
                if (hold_off_req && !held_long) begin
                    held_long = 1'b1;
                    hold = HOLD_OFF_CYCLES;
                end else if (burst_left > 0) begin
                    burst_left--;
                    hold = 0;
                end else begin
                    if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 80);
                    hold = $urandom_range(0, MAX_GAP);
                end
                if (hold > 0) out_ch.ready <= 1'b0;
            end else if (!out_ch.ready) begin
                if (hold > 0) hold--;
                if (hold == 0) out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        int idle_cycles;
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offer one compressed byte after a random gap and hold it until taken
    task automatic send_compressed(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.compressed_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        n_items++;
    endtask

    task automatic send_match(input int len, input int off);
        logic [5:0] l6;
        logic [9:0] o10;
        l6  = len[5:0];
        o10 = off[9:0];
        send_compressed({l6, o10[9:8]});
        send_compressed(o10[7:0]);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Write the registers in random order; the mode write may be skipped
    task automatic configure(input logic m, input logic [15:0] len, input bit write_mode);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_OUTPUT_LENGTH, len);
            if (write_mode) write_reg(CFG_MODE, {15'd0, m});
        end else begin
            if (write_mode) write_reg(CFG_MODE, {15'd0, m});
            write_reg(CFG_OUTPUT_LENGTH, len);
        end
        cfg_we <= 1'b0;
        if (write_mode) gen_mode = m;
        gen_length = len;
    endtask

    // Drop valid, wait for every predicted byte, then let the block go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic rle_stream(input int max_groups);
        int         groups;
        int         r;
        logic [7:0] ctrl;
        groups = gen_length >> 3;
        if (groups > max_groups) groups = max_groups;
        repeat (groups) begin
            r = $urandom_range(0, 5);
            ctrl = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
            send_compressed(ctrl);
            send_compressed(8'($urandom));
            for (int b = 7; b >= 0; b--) begin
                if (ctrl[b]) send_compressed(8'($urandom));
            end
        end
        // Trailing control byte, ignored once the stream is complete
        send_compressed(8'($urandom));
    endtask

    task automatic lzss_stream(input int max_items);
        int         produced;
        int         first_item;
        int         len;
        int         off;
        int         left;
        logic [7:0] ctrl;
        produced   = 0;
        first_item = n_items;
        while (produced < gen_length && n_items - first_item < max_items) begin
            ctrl = 8'($urandom);
            send_compressed(ctrl);
            for (int b = 7; b >= 0 && produced < gen_length; b--) begin
                if (ctrl[b]) begin
                    case ($urandom_range(0, 7))
                        0:       len = 0;
                        1, 2, 3,
                        4:       len = $urandom_range(1, 8);
                        default: len = $urandom_range(0, 63);
                    endcase
                    case ($urandom_range(0, 15))
                        0:          off = 0;
                        1:          off = 1023;
                        2, 3, 4, 5: off = $urandom_range(1, 16);
                        default:    off = $urandom_range(0, 1023);
                    endcase
                    send_match(len, off);
                    left = gen_length - produced;
                    produced += (len < left) ? len : left;
                end else begin
                    send_compressed(8'($urandom));
                    produced++;
                end
            end
        end
        send_compressed(8'($urandom));
    endtask

    // Long LZSS stream: wraps the ring, uses zero offsets, stalls the receiver
    task automatic ring_wrap_stream();
        hold_off_req = 1'b1;
        configure(1'b1, 16'hFFFF, 1'b1);
        send_compressed(8'h00);
        repeat (8) send_compressed(8'($urandom));
        repeat (2) begin
            send_compressed(8'hFF);
            repeat (8) begin
                if ($urandom_range(0, 1)) send_match(63, $urandom_range(1, 8));
                else                      send_match(63, $urandom_range(1, 1023));
            end
        end
        send_compressed(8'hF0);
        repeat (4) send_match(63, 0);
        repeat (4) send_compressed(8'($urandom));
        settle();
    endtask

    initial begin
        logic [7:0] lits [8];
        int         phase_no;
        int         r;
        int         s;
        logic       m;
        logic [15:0] len;
        lits = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
        tx_burst     = 1'b0;
        hold_off_req = 1'b0;
        n_items      = 0;
        gen_mode     = 1'b0;
        gen_length   = '0;
        in_ch.valid           <= 1'b0;
        in_ch.compressed_byte <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MODE;
        cfg_data  <= '0;
        i_rst_n   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Mode 0, length not a multiple of eight: an all-fill group, then all literals
        configure(1'b0, 16'd19, 1'b1);
        send_compressed(8'h00);
        send_compressed(8'hFF);
        send_compressed(8'hFF);
        send_compressed(8'h00);
        foreach (lits[i]) send_compressed(lits[i]);
        send_compressed(8'h12);
        settle();

        // Mode 1: literal, zero-length match, farthest offset, overlong match cut off
        configure(1'b1, 16'd20, 1'b1);
        send_compressed(8'h70);
        send_compressed(8'hA5);
        send_match(0, 0);
        send_match(5, 1023);
        send_match(63, 1);
        send_compressed(8'h00);
        settle();

        // Zero length: every byte is ignored
        configure(1'b1, 16'd0, 1'b0);
        send_compressed(8'h3C);
        send_compressed(8'hC3);
        settle();

        phase_no = 0;
        while (n_items < ITEM_TARGET) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if (phase_no == 2) begin
                ring_wrap_stream();
            end else begin
                r = $urandom_range(0, 9);
                m = (r >= 4);
                s = $urandom_range(0, 15);
                if (s == 0)      len = 16'd0;
                else if (s == 1) len = 16'hFFFF;
                else if (s == 2) len = 16'($urandom_range(1, 7));
                else if (m)      len = 16'($urandom_range(8, 250));
                else             len = 16'($urandom_range(8, 96));
                configure(m, len, ($urandom_range(0, 3) != 0) || (m != gen_mode));
                if (r == 9)        repeat ($urandom_range(5, 15)) send_compressed(8'($urandom));
                else if (gen_mode) lzss_stream(40);
                else               rle_stream(6);
                settle();
            end
            phase_no++;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/mrld_pkg.sv
rtl/core/mrld_in_if.sv
rtl/core/mrld_out_if.sv
rtl/core/mrld_ram.sv
rtl/core/mrld_hist.sv
rtl/core/mask_rle_and_lzss_decoder.sv
dv/mrld_decode_checker.sv
dv/tb_mask_rle_and_lzss_decoder.sv
